### sv/assert_macros.svh
// Assertion macros shared by the queue RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold expr at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: expression does not hold");

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### sv/teq_pkg.sv
// Package for the three-ended queue: operation and status codes,
// request type and default sizes. Depends on nothing.
package teq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int IO_WIDTH       = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_PUSH_MID   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_REAR   = 3'd4,
    OP_POP_MID    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                valid;
    logic [2:0]          op;
    logic [IO_WIDTH-1:0] value;
  } req_t;

endpackage

### sv/teq_req_reg.sv
// Input register of the three-ended queue: captures one accepted request.
// Depends on teq_pkg.
module teq_req_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [2:0]    operation,
  input  logic [31:0]   value,
  output teq_pkg::req_t req
);
  import teq_pkg::*;

  logic                valid;
  logic [2:0]          op;
  logic [IO_WIDTH-1:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= operation;
      data <= value;
    end
  end

  assign req = {valid, op, data};

endmodule

### sv/teq_store.sv
// Entry array, count and result register of the three-ended queue.
// Applies one registered request per cycle. Depends on teq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module teq_store #(
  parameter int DEPTH      = teq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = teq_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  teq_pkg::req_t           req,
  output logic                    done,
  output logic [1:0]              status,
  output logic [31:0]             removed_value,
  output logic [CNT_W-1:0]        occupancy,
  output logic [31:0]             front_value,
  output logic [31:0]             rear_value
);
  import teq_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic [DATA_WIDTH-1:0] entries [DEPTH];
  logic [DATA_WIDTH-1:0] entries_next [DEPTH];
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      pos;
  logic [CNT_W-1:0]      mid;
  logic [CNT_W-1:0]      rear_idx;
  logic [DATA_WIDTH-1:0] din;
  logic [DATA_WIDTH-1:0] rem_sel;
  logic [DATA_WIDTH-1:0] rear_sel;
  logic                  is_push;
  logic                  is_pop;
  logic                  full;
  logic                  empty;
  logic                  do_ins;
  logic                  do_rem;
  status_t               status_next;
  op_t                   op;

  always_comb begin
    op      = op_t'(req.op);
    full    = (count == DEPTH_C);
    empty   = (count == '0);
    mid     = CNT_W'(({1'b0, count} + {1'b0, ONE_C}) >> 1);
    din     = DATA_WIDTH'(signed'(req.value));
    is_push = 1'b0;
    is_pop  = 1'b0;
    pos     = '0;
    unique case (op)
      OP_PUSH_FRONT: begin
        is_push = 1'b1;
      end
      OP_PUSH_REAR: begin
        is_push = 1'b1;
        pos     = count;
      end
      OP_PUSH_MID: begin
        is_push = 1'b1;
        pos     = mid;
      end
      OP_POP_FRONT: begin
        is_pop = 1'b1;
      end
      OP_POP_REAR: begin
        is_pop = 1'b1;
        pos    = count - ONE_C;
      end
      OP_POP_MID: begin
        is_pop = 1'b1;
        pos    = mid - ONE_C;
      end
      default: begin
        is_push = 1'b0;
      end
    endcase
    do_ins = req.valid && is_push && !full;
    do_rem = req.valid && is_pop && !empty;

    priority if (is_push && full) begin
      status_next = ST_FULL;
    end else if (is_pop && empty) begin
      status_next = ST_EMPTY;
    end else begin
      status_next = ST_DONE;
    end

    count_next = count;
    if (do_ins) begin
      count_next = count + ONE_C;
    end else if (do_rem) begin
      count_next = count - ONE_C;
    end
    rear_idx = count_next - ONE_C;
  end

  // Shift each entry toward or away from the insert or remove position.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_next[i] = entries[i];
      if (do_ins) begin
        if (CNT_W'(i) == pos) begin
          entries_next[i] = din;
        end else if (CNT_W'(i) > pos && i > 0) begin
          entries_next[i] = entries[(i > 0) ? i - 1 : 0];
        end
      end else if (do_rem) begin
        if (CNT_W'(i) >= pos && i < DEPTH - 1) begin
          entries_next[i] = entries[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    rem_sel  = '0;
    rear_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i) == pos) begin
        rem_sel = rem_sel | entries[i];
      end
      if (CNT_W'(i) == rear_idx) begin
        rear_sel = rear_sel | entries_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      entries[i] <= entries_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    status        <= status_next;
    occupancy     <= count_next;
    removed_value <= do_rem ? 32'(signed'(rem_sel)) : '0;
    front_value   <= (count_next != '0) ? 32'(signed'(entries_next[0])) : '0;
    rear_value    <= (count_next != '0) ? 32'(signed'(rear_sel)) : '0;
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= DEPTH_C)
  `ASSERT_NEXT(a_strobe_follows, clk, rst, req.valid, done)
  `ASSERT_IMPLY(a_occ_matches, clk, rst, done, occupancy == count)
  `ASSERT_NEXT(a_reject_holds, clk, rst, req.valid && !do_ins && !do_rem, count == $past(count))

endmodule

### sv/three_ended_queue.sv
// Top level of the bounded three-ended queue.
// Depends on teq_pkg, teq_req_reg and teq_store.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. busy
//   is always low, so a new request may be issued in every cycle.
//   operation selects push front, push rear, push middle, pop front, pop rear
//   or pop middle; value is the element for pushes.
//   Each request yields one result, via teq_req_reg and teq_store: done is
//   high for one cycle with status, removed_value, occupancy, front_value and
//   rear_value. Results come out in request order, one per cycle at most.
//   Throughput is one request per cycle: the entry array is a row of
//   registers that shifts by one place in the same cycle the request is
//   applied, so the next request always sees the updated queue.
//   A push when full or a pop when empty returns a rejected status and
//   leaves the queue unchanged.
//   Reset empties the queue and drops any request in flight.
//   The receiver cannot stall: each result is valid for its one cycle only.
module three_ended_queue #(
  parameter int DEPTH      = teq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = teq_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       operation,
  input  logic [31:0]      value,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      removed_value,
  output logic [CNT_W-1:0] occupancy,
  output logic [31:0]      front_value,
  output logic [31:0]      rear_value
);
  import teq_pkg::*;

  req_t req;
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  teq_req_reg u_req (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .value     (value),
    .req       (req)
  );

  teq_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .done          (done),
    .status        (status),
    .removed_value (removed_value),
    .occupancy     (occupancy),
    .front_value   (front_value),
    .rear_value    (rear_value)
  );

endmodule

### tb/three_ended_queue_tb.sv
// Testbench for three_ended_queue: drives push, pop and unused-opcode requests through the
// start/busy handshake, predicts each result and checks the done strobe.
// Depends on teq_pkg and the three_ended_queue RTL.
`timescale 1ns / 100ps

module three_ended_queue_tb;
  import teq_pkg::*;

  localparam int          QDEPTH        = DEPTH_DEF;
  localparam int          OCC_W         = $clog2(DEPTH_DEF + 1);
  localparam logic [2:0]  OP_UNUSED_LO  = 3'd6;
  localparam logic [2:0]  OP_UNUSED_HI  = 3'd7;
  localparam int          REPORT_LIMIT  = 10;
  localparam int          RANDOM_PER_PH = 515;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
  } teque_req_t;

  typedef struct packed {
    status_t            status;
    logic [31:0]        removed;
    logic [OCC_W-1:0]   occupancy;
    logic [31:0]        front;
    logic [31:0]        rear;
  } teque_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [2:0]       operation = '0;
  logic [31:0]      value = '0;
  logic             done;
  logic [1:0]       status;
  logic [31:0]      removed_value;
  logic [OCC_W-1:0] occupancy;
  logic [31:0]      front_value;
  logic [31:0]      rear_value;

  teque_req_t    queued_requests[$];
  teque_result_t awaited_results[$];
  logic [31:0]   teque_mem [0:QDEPTH-1];
  int unsigned   teque_count = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   idle_pct = 0;
  logic          req_taken = 1'b0;

  three_ended_queue uut (.*);

  always #1 clk = ~clk;

  function automatic teque_result_t apply_teque_op(input logic [2:0] op,
                                                   input logic [31:0] val);
    teque_result_t res;
    int unsigned   pos;
    res = '0;
    res.status = ST_DONE;
    pos = 0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR, OP_PUSH_MID: begin
        if (teque_count >= QDEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_REAR) pos = teque_count;
          else if (op == OP_PUSH_MID) pos = (teque_count + 1) / 2;
          for (int i = teque_count; i > pos; i--) teque_mem[i] = teque_mem[i-1];
          teque_mem[pos] = val;
          teque_count++;
        end
      end
      OP_POP_FRONT, OP_POP_REAR, OP_POP_MID: begin
        if (teque_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_REAR) pos = teque_count - 1;
          else if (op == OP_POP_MID) pos = (teque_count + 1) / 2 - 1;
          res.removed = teque_mem[pos];
          for (int i = pos; i + 1 < teque_count; i++) teque_mem[i] = teque_mem[i+1];
          teque_count--;
        end
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(teque_count);
    if (teque_count > 0) begin
      res.front = teque_mem[0];
      res.rear  = teque_mem[teque_count-1];
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch on %s at %0t: expected %h, got %h", field, $time, want, got);
  endtask

  task automatic add_request(input logic [2:0] op, input logic [31:0] val);
    teque_req_t req;
    req.op    = op;
    req.value = val;
    queued_requests.push_back(req);
  endtask

  task automatic add_random_requests(input int unsigned count);
    int unsigned push_pct;
    int unsigned roll;
    logic [2:0]  op;
    logic [31:0] val;
    push_pct = 50;
    for (int unsigned i = 0; i < count; i++) begin
      // bias runs of requests so the queue swings between empty and full
      if (i % 40 == 0) begin
        case ($urandom_range(2, 0))
          0: push_pct = 75;
          1: push_pct = 25;
          default: push_pct = 50;
        endcase
      end
      roll = $urandom_range(99, 0);
      if (roll < 3)
        op = ($urandom_range(1, 0) != 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
      else if (roll < 3 + push_pct * 97 / 100)
        op = 3'($urandom_range(OP_PUSH_MID, OP_PUSH_FRONT));
      else
        op = 3'($urandom_range(OP_POP_MID, OP_POP_FRONT));
      case ($urandom_range(9, 0))
        0: val = 32'h8000_0000;
        1: val = 32'h7fff_ffff;
        2: val = 32'hffff_ffff;
        3: val = 32'h0000_0000;
        default: val = $urandom;
      endcase
      add_request(op, val);
    end
  endtask

  // drive requests on the falling edge; hold until the request is taken
  always @(negedge clk) begin
    teque_req_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (queued_requests.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
        nxt = queued_requests.pop_front();
        start     <= 1'b1;
        operation <= nxt.op;
        value     <= nxt.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // check results, then predict the request taken at this edge
  always @(posedge clk) begin
    teque_result_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("result with none expected", 32'h0, removed_value);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status)
            flag_mismatch("status", 32'(want.status), 32'(status));
          if (removed_value !== want.removed)
            flag_mismatch("removed_value", want.removed, removed_value);
          if (occupancy !== want.occupancy)
            flag_mismatch("occupancy", 32'(want.occupancy), 32'(occupancy));
          if (front_value !== want.front)
            flag_mismatch("front_value", want.front, front_value);
          if (rear_value !== want.rear)
            flag_mismatch("rear_value", want.rear, rear_value);
        end
      end
      if (start && !busy) awaited_results.push_back(apply_teque_op(operation, value));
      req_taken <= start && !busy;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: idle_pct = 14;
        1: idle_pct = 59;
        default: idle_pct = 0;
      endcase
      if (phase == 0) begin
        add_request(OP_POP_FRONT, 32'hffff_ffff);
        add_request(OP_POP_REAR, 32'h0);
        add_request(OP_POP_MID, 32'h0);
        add_request(OP_UNUSED_LO, 32'h1234_5678);
        add_request(OP_PUSH_FRONT, 32'h7fff_ffff);
        add_request(OP_PUSH_REAR, 32'h8000_0000);
        add_request(OP_POP_MID, 32'h0);
        add_request(OP_PUSH_MID, 32'hffff_ffff);
        add_request(OP_PUSH_MID, 32'h0000_0000);
        add_request(OP_POP_MID, 32'h0);
        for (int i = 0; i < 14; i++)
          add_request(3'(i % 3), (i % 2 != 0) ? 32'ha5a5_a5a5 : 32'h5a5a_5a5a);
        add_request(OP_PUSH_FRONT, 32'h1);
        add_request(OP_UNUSED_HI, 32'h0);
      end
      add_random_requests(RANDOM_PER_PH);
      while (queued_requests.size() != 0 || start) @(posedge clk);
    end

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
